// File: sv/sspar_pkg.sv
// Shared types and constants for the screen-sync datagram parser.
// No dependencies; used by every module of the parser.
`timescale 1ns / 1ps

package sspar_pkg;

   localparam int ID_BYTES     = 32;
   localparam int NAME_BYTES   = 64;
   localparam int MAX_DISPLAYS = 16;

   localparam int HDR_LEN       = 6;
   localparam int PROTO_VERSION = 1;
   localparam int REC_LEN       = 4 * 4 + 1;
   localparam int ID_END        = HDR_LEN + ID_BYTES;
   localparam int NAME_START    = ID_END + 1;

   localparam int POS_W  = 16;
   localparam int CALC_W = 18;

   localparam int Q_DEPTH = 4;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
   localparam int Q_IDX_W = $clog2(Q_DEPTH);

   localparam int RSP_DATA_W = 216;

   localparam logic [3:0][7:0] MAGIC = {8'h53, 8'h54, 8'h4C, 8'h41};

   typedef enum logic [1:0] {
      MSG_UNKNOWN = 2'd0,
      MSG_QUERY   = 2'd1,
      MSG_REPLY   = 2'd2,
      MSG_PUSH    = 2'd3
   } msg_type_type;

   typedef enum logic [1:0] {
      KIND_ID     = 2'd0,
      KIND_NAME   = 2'd1,
      KIND_RECORD = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           result_kind;
      logic [7:0]         text_byte;
      logic [7:0]         item_index;
      logic signed [31:0] rect_x;
      logic signed [31:0] rect_y;
      logic signed [31:0] rect_width;
      logic signed [31:0] rect_height;
      logic               primary_flag;
      msg_type_type       message_type;
      logic               message_ok;
      logic signed [31:0] edge_code;
      logic signed [31:0] target_screen;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

endpackage

// File: sv/sspar_parse_core.sv
// Parser state and per-byte decode: header check, id, records, zone name and words.
// Produces up to two results per byte. Depends on sspar_pkg.
`timescale 1ns / 1ps

module sspar_parse_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   output sspar_pkg::push_type push
);

   logic [sspar_pkg::POS_W-1:0] pos_ff, pos_in;
   sspar_pkg::msg_type_type     type_ff, type_in;
   logic                        err_ff, err_in;
   logic [7:0]                  rtot_ff, rtot_in;
   logic [7:0]                  rnum_ff, rnum_in;
   logic [4:0]                  rbyte_ff, rbyte_in;
   logic [31:0]                 shift_ff, shift_in;
   logic [31:0]                 hx_ff, hx_in;
   logic [31:0]                 hy_ff, hy_in;
   logic [31:0]                 hw_ff, hw_in;
   logic [7:0]                  nlen_ff, nlen_in;
   logic [31:0]                 hedge_ff, hedge_in;

   sspar_pkg::rsp_item_type     content;
   sspar_pkg::rsp_item_type     end_item;
   logic                        content_vld;

   logic [sspar_pkg::CALC_W-1:0] p;
   logic [sspar_pkg::CALC_W-1:0] tail;
   logic [sspar_pkg::CALC_W-1:0] need;
   logic [sspar_pkg::CALC_W-1:0] got;
   logic [sspar_pkg::CALC_W-1:0] idx;
   logic                         ok;

   always_comb begin
      pos_in   = pos_ff;
      type_in  = type_ff;
      err_in   = err_ff;
      rtot_in  = rtot_ff;
      rnum_in  = rnum_ff;
      rbyte_in = rbyte_ff;
      shift_in = shift_ff;
      hx_in    = hx_ff;
      hy_in    = hy_ff;
      hw_in    = hw_ff;
      nlen_in  = nlen_ff;
      hedge_in = hedge_ff;

      p    = sspar_pkg::CALC_W'(pos_ff);
      tail = sspar_pkg::CALC_W'(sspar_pkg::NAME_START) + sspar_pkg::CALC_W'(nlen_ff);
      idx  = '0;

      content_vld          = 1'b0;
      content              = '0;
      content.message_type = type_ff;

      if (!err_ff) begin
         if (p < sspar_pkg::CALC_W'(4)) begin
            if (data_byte != sspar_pkg::MAGIC[p[1:0]]) err_in = 1'b1;
         end else if (p == sspar_pkg::CALC_W'(4)) begin
            if (data_byte != 8'(sspar_pkg::PROTO_VERSION)) err_in = 1'b1;
         end else if (p == sspar_pkg::CALC_W'(5)) begin
            if (data_byte inside {[8'd1 : 8'd3]}) begin
               type_in = sspar_pkg::msg_type_type'(data_byte[1:0]);
            end else begin
               type_in = sspar_pkg::MSG_UNKNOWN;
               err_in  = 1'b1;
            end
         end else if (p < sspar_pkg::CALC_W'(sspar_pkg::ID_END)) begin
            idx                 = p - sspar_pkg::CALC_W'(sspar_pkg::HDR_LEN);
            content_vld         = 1'b1;
            content.result_kind = sspar_pkg::KIND_ID;
            content.text_byte   = (idx == sspar_pkg::CALC_W'(sspar_pkg::ID_BYTES - 1)) ?
                                  8'd0 : data_byte;
            content.item_index  = idx[7:0];
         end else if (p == sspar_pkg::CALC_W'(sspar_pkg::ID_END) &&
                      type_ff == sspar_pkg::MSG_REPLY) begin
            rtot_in = data_byte;
            if (data_byte > 8'(sspar_pkg::MAX_DISPLAYS)) err_in = 1'b1;
         end else if (p == sspar_pkg::CALC_W'(sspar_pkg::ID_END) &&
                      type_ff == sspar_pkg::MSG_PUSH) begin
            nlen_in = data_byte;
            if (9'(data_byte) > 9'(sspar_pkg::NAME_BYTES - 1)) err_in = 1'b1;
         end else if (type_ff == sspar_pkg::MSG_REPLY && rnum_ff < rtot_ff) begin
            if (rbyte_ff < 5'd16) begin
               shift_in = {shift_ff[23:0], data_byte};
               if (rbyte_ff == 5'd3) hx_in = shift_in;
               else if (rbyte_ff == 5'd7) hy_in = shift_in;
               else if (rbyte_ff == 5'd11) hw_in = shift_in;
               rbyte_in = rbyte_ff + 5'd1;
            end else begin
               content_vld          = 1'b1;
               content.result_kind  = sspar_pkg::KIND_RECORD;
               content.item_index   = rnum_ff;
               content.rect_x       = hx_ff;
               content.rect_y       = hy_ff;
               content.rect_width   = hw_ff;
               content.rect_height  = shift_ff;
               content.primary_flag = (data_byte != 8'd0);
               rnum_in              = rnum_ff + 8'd1;
               rbyte_in             = 5'd0;
            end
         end else if (type_ff == sspar_pkg::MSG_PUSH) begin
            if (p < tail) begin
               idx                 = p - sspar_pkg::CALC_W'(sspar_pkg::NAME_START);
               content_vld         = 1'b1;
               content.result_kind = sspar_pkg::KIND_NAME;
               content.text_byte   = data_byte;
               content.item_index  = idx[7:0];
            end else if (p < tail + sspar_pkg::CALC_W'(8)) begin
               shift_in = {shift_ff[23:0], data_byte};
               if (p == tail + sspar_pkg::CALC_W'(3)) hedge_in = shift_in;
            end
         end
      end

      // end-of-datagram result sees the state after this byte
      got = p + sspar_pkg::CALC_W'(1);
      case (type_in)
         sspar_pkg::MSG_QUERY: need = sspar_pkg::CALC_W'(sspar_pkg::ID_END);
         sspar_pkg::MSG_REPLY: need = sspar_pkg::CALC_W'(sspar_pkg::NAME_START) +
                                      sspar_pkg::CALC_W'(rtot_in) *
                                      sspar_pkg::CALC_W'(sspar_pkg::REC_LEN);
         sspar_pkg::MSG_PUSH:  need = sspar_pkg::CALC_W'(sspar_pkg::NAME_START) +
                                      sspar_pkg::CALC_W'(nlen_in) + sspar_pkg::CALC_W'(8);
         default:              need = '1;
      endcase
      ok = !err_in && type_in != sspar_pkg::MSG_UNKNOWN && got >= need;

      end_item              = '0;
      end_item.result_kind  = sspar_pkg::KIND_END;
      end_item.message_type = type_in;
      end_item.item_index   = (type_in == sspar_pkg::MSG_REPLY) ? rtot_in : 8'd0;
      end_item.message_ok   = ok;
      if (ok && type_in == sspar_pkg::MSG_PUSH) begin
         end_item.edge_code     = hedge_in;
         end_item.target_screen = shift_in;
      end

      if (last_byte) begin
         pos_in   = '0;
         type_in  = sspar_pkg::MSG_UNKNOWN;
         err_in   = 1'b0;
         rtot_in  = '0;
         rnum_in  = '0;
         rbyte_in = '0;
         shift_in = '0;
         hx_in    = '0;
         hy_in    = '0;
         hw_in    = '0;
         nlen_in  = '0;
         hedge_in = '0;
      end else if (pos_ff != '1) begin
         pos_in = pos_ff + sspar_pkg::POS_W'(1);
      end
   end

   always_comb begin
      push.count  = 2'(content_vld) + 2'(last_byte);
      push.first  = content_vld ? content : end_item;
      push.second = end_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         type_ff  <= sspar_pkg::MSG_UNKNOWN;
         err_ff   <= 1'b0;
         rtot_ff  <= '0;
         rnum_ff  <= '0;
         rbyte_ff <= '0;
         shift_ff <= '0;
         hx_ff    <= '0;
         hy_ff    <= '0;
         hw_ff    <= '0;
         nlen_ff  <= '0;
         hedge_ff <= '0;
      end else if (step) begin
         pos_ff   <= pos_in;
         type_ff  <= type_in;
         err_ff   <= err_in;
         rtot_ff  <= rtot_in;
         rnum_ff  <= rnum_in;
         rbyte_ff <= rbyte_in;
         shift_ff <= shift_in;
         hx_ff    <= hx_in;
         hy_ff    <= hy_in;
         hw_ff    <= hw_in;
         nlen_ff  <= nlen_in;
         hedge_ff <= hedge_in;
      end
   end

endmodule

// File: sv/sspar_rsp_queue.sv
// Small result queue: takes up to two results per cycle, hands out one per beat.
// Depends on sspar_pkg.
`timescale 1ns / 1ps

module sspar_rsp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_en,
   input  sspar_pkg::push_type         push,
   input  logic                        pop_ready,
   output logic                        head_valid,
   output sspar_pkg::rsp_item_type     head,
   output logic                        room
);

   sspar_pkg::rsp_item_type          q_ff [sspar_pkg::Q_DEPTH];
   sspar_pkg::rsp_item_type          q_in [sspar_pkg::Q_DEPTH];
   logic [sspar_pkg::Q_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [sspar_pkg::Q_CNT_W-1:0]    base;
   logic [sspar_pkg::Q_CNT_W-1:0]    n_push;
   logic                             pop;

   assign head_valid = (cnt_ff != '0);
   assign head       = q_ff[0];
   assign room       = (cnt_ff <= sspar_pkg::Q_CNT_W'(sspar_pkg::Q_DEPTH - 2));
   assign pop        = head_valid && pop_ready;

   always_comb begin
      base   = cnt_ff - sspar_pkg::Q_CNT_W'(pop);
      n_push = push_en ? sspar_pkg::Q_CNT_W'(push.count) : '0;
      for (int i = 0; i < sspar_pkg::Q_DEPTH; i++) begin
         q_in[i] = q_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < sspar_pkg::Q_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
      end
      for (int i = 0; i < sspar_pkg::Q_DEPTH; i++) begin
         if (n_push != '0 && sspar_pkg::Q_CNT_W'(i) == base) q_in[i] = push.first;
         if (n_push == sspar_pkg::Q_CNT_W'(2) &&
             sspar_pkg::Q_CNT_W'(i) == base + sspar_pkg::Q_CNT_W'(1)) begin
            q_in[i] = push.second;
         end
      end
      cnt_in = base + n_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < sspar_pkg::Q_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule

// File: sv/screen_sync_message_parser.sv
// Screen-sync datagram parser top level: input beat register, parse core, result queue.
// Depends on sspar_pkg, sspar_parse_core and sspar_rsp_queue.
//
// Takes one datagram byte per beat (req_tlast on the final byte) and gives id bytes,
// name bytes, finished display records and one end-of-message result per datagram,
// the end result carrying the ok flag. Throughput is one byte per cycle while the queue
// has room: each byte is decoded combinationally from the input register, and a
// four-entry result queue absorbs the second result of a final byte. A byte's results
// are registered in the result queue. req_tready drops when a byte waits in the input
// register and the queue holds three or more results, which takes a result-side stall
// or a run of final bytes that arrive faster than their two results each can drain.
`timescale 1ns / 1ps

module screen_sync_message_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // data_byte
   input  logic                                req_tlast,  // last_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // text_byte, item_index, rect_x, rect_y, rect_width, rect_height, primary_flag,
   // message_type, message_ok, edge_code, target_screen, zero pad
   output logic [sspar_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [1:0]                          rsp_tuser   // result_kind
);

   logic                    in_vld_ff, in_vld_in;
   logic [7:0]              in_byte_ff;
   logic                    in_last_ff;
   logic                    accept;
   logic                    step;
   logic                    room;
   sspar_pkg::push_type     push;
   sspar_pkg::rsp_item_type head;

   assign step       = in_vld_ff && room;
   assign req_tready = !in_vld_ff || step;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept) in_vld_in = 1'b1;
      else if (step) in_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   sspar_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .push      (push)
   );

   sspar_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (step),
      .push       (push),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .room       (room)
   );

   assign rsp_tuser = head.result_kind;
   assign rsp_tdata = {4'd0,
                       head.target_screen,
                       head.edge_code,
                       head.message_ok,
                       head.message_type,
                       head.primary_flag,
                       head.rect_height,
                       head.rect_width,
                       head.rect_y,
                       head.rect_x,
                       head.item_index,
                       head.text_byte};

endmodule

// File: tb/sv/testbench.sv
// Self-checking bench for screen_sync_message_parser: directed and random datagrams are
// streamed in and every result beat is checked against an in-bench parser model.
// Depends on sspar_pkg and the parser RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int TOTAL_BYTES  = 1100;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 100_000;
   localparam int PRINT_CAP    = 200;

   typedef struct packed {
      logic [7:0] value;
      logic       is_last;
   } rx_byte_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata = 8'h00;
   logic                             req_tlast = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [sspar_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                       rsp_tuser;

   screen_sync_message_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rx_byte_type             rx_bytes_pending[$];
   sspar_pkg::rsp_item_type expected_results[$];
   logic [7:0]              frame[$];

   // parser model state
   logic [15:0]             parse_pos;
   sspar_pkg::msg_type_type parse_type;
   logic                    parse_err;
   logic [7:0]              rec_total;
   logic [7:0]              rec_num;
   logic [4:0]              rec_byte;
   logic [31:0]             shift_word;
   logic [31:0]             x_word;
   logic [31:0]             y_word;
   logic [31:0]             w_word;
   logic [7:0]              zone_name_size;
   logic [31:0]             edge_word;

   int                      mismatches = 0;
   int                      beats_accepted = 0;
   int                      results_checked = 0;
   int                      frames_sent = 0;
   int                      ends_ok = 0;
   int                      kind_seen[4] = '{0, 0, 0, 0};
   int                      cycle_count = 0;
   logic                    beat_taken = 1'b0;
   int                      gap_left = 0;
   int                      burst_left = 0;
   int                      hold_left = 0;
   logic                    hold_done = 1'b0;
   int                      stall_phase = 0;
   int                      stall_mode = 0;
   rx_byte_type             next_byte;
   sspar_pkg::rsp_item_type seen_item;
   sspar_pkg::rsp_item_type want_item;

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------- parser model ----------------

   task automatic clear_parser_state();
      parse_pos      = '0;
      parse_type     = sspar_pkg::MSG_UNKNOWN;
      parse_err      = 1'b0;
      rec_total      = '0;
      rec_num        = '0;
      rec_byte       = '0;
      shift_word     = '0;
      x_word         = '0;
      y_word         = '0;
      w_word         = '0;
      zone_name_size = '0;
      edge_word      = '0;
   endtask

   function automatic sspar_pkg::rsp_item_type blank_row(input sspar_pkg::kind_type k);
      sspar_pkg::rsp_item_type r;
      r = '0;
      r.result_kind = k;
      r.message_type = parse_type;
      return r;
   endfunction

   task automatic predict_beat(input logic [7:0] b, input logic is_last);
      int unsigned             p;
      int unsigned             needed;
      logic                    ok;
      sspar_pkg::rsp_item_type row;
      p = parse_pos;
      if (!parse_err) begin
         if (p < 4) begin
            if (b != sspar_pkg::MAGIC[p]) parse_err = 1'b1;
         end else if (p == 4) begin
            if (b != sspar_pkg::PROTO_VERSION) parse_err = 1'b1;
         end else if (p == 5) begin
            if (b >= 1 && b <= 3) begin
               parse_type = sspar_pkg::msg_type_type'(b[1:0]);
            end else begin
               parse_type = sspar_pkg::MSG_UNKNOWN;
               parse_err = 1'b1;
            end
         end else if (p < sspar_pkg::ID_END) begin
            row = blank_row(sspar_pkg::KIND_ID);
            row.text_byte = (p - sspar_pkg::HDR_LEN == sspar_pkg::ID_BYTES - 1) ? 8'h00 : b;
            row.item_index = 8'(p - sspar_pkg::HDR_LEN);
            expected_results.push_back(row);
         end else if (p == sspar_pkg::ID_END && parse_type == sspar_pkg::MSG_REPLY) begin
            rec_total = b;
            if (b > sspar_pkg::MAX_DISPLAYS) parse_err = 1'b1;
         end else if (p == sspar_pkg::ID_END && parse_type == sspar_pkg::MSG_PUSH) begin
            zone_name_size = b;
            if (b > sspar_pkg::NAME_BYTES - 1) parse_err = 1'b1;
         end else if (parse_type == sspar_pkg::MSG_REPLY && rec_num < rec_total) begin
            if (rec_byte < 16) begin
               shift_word = {shift_word[23:0], b};
               if (rec_byte == 3) x_word = shift_word;
               else if (rec_byte == 7) y_word = shift_word;
               else if (rec_byte == 11) w_word = shift_word;
               rec_byte++;
            end else begin
               row = blank_row(sspar_pkg::KIND_RECORD);
               row.item_index = rec_num;
               row.rect_x = x_word;
               row.rect_y = y_word;
               row.rect_width = w_word;
               row.rect_height = shift_word;
               row.primary_flag = (b != 8'h00);
               expected_results.push_back(row);
               rec_num++;
               rec_byte = '0;
            end
         end else if (parse_type == sspar_pkg::MSG_PUSH) begin
            if (p < sspar_pkg::NAME_START + zone_name_size) begin
               row = blank_row(sspar_pkg::KIND_NAME);
               row.text_byte = b;
               row.item_index = 8'(p - sspar_pkg::NAME_START);
               expected_results.push_back(row);
            end else if (p < sspar_pkg::NAME_START + zone_name_size + 8) begin
               shift_word = {shift_word[23:0], b};
               if (p == sspar_pkg::NAME_START + zone_name_size + 3) edge_word = shift_word;
            end
         end
      end
      if (is_last) begin
         case (parse_type)
            sspar_pkg::MSG_QUERY: needed = sspar_pkg::ID_END;
            sspar_pkg::MSG_REPLY: needed = sspar_pkg::ID_END + 1 +
                                           rec_total * sspar_pkg::REC_LEN;
            sspar_pkg::MSG_PUSH:  needed = sspar_pkg::ID_END + 1 + zone_name_size + 8;
            default:              needed = 32'hFFFF_FFFF;
         endcase
         ok = !parse_err && parse_type != sspar_pkg::MSG_UNKNOWN && (p + 1 >= needed);
         row = blank_row(sspar_pkg::KIND_END);
         row.item_index = (parse_type == sspar_pkg::MSG_REPLY) ? rec_total : 8'h00;
         row.message_ok = ok;
         if (ok && parse_type == sspar_pkg::MSG_PUSH) begin
            row.edge_code = edge_word;
            row.target_screen = shift_word;
         end
         expected_results.push_back(row);
         clear_parser_state();
      end else if (parse_pos != 16'hFFFF) begin
         parse_pos++;
      end
   endtask

   // ---------------- datagram builders ----------------

   function automatic logic [31:0] extreme_word(input int i);
      case (i % 4)
         0:       return 32'h0000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      if ($urandom_range(0, 3) == 0) return extreme_word($urandom_range(0, 3));
      return $urandom;
   endfunction

   function automatic logic [7:0] pick_flag();
      if ($urandom_range(0, 1) == 0) return 8'h00;
      return 8'($urandom);
   endfunction

   task automatic start_frame(input logic [7:0] type_byte);
      frame.delete();
      for (int i = 0; i < 4; i++) frame.push_back(sspar_pkg::MAGIC[i]);
      frame.push_back(8'(sspar_pkg::PROTO_VERSION));
      frame.push_back(type_byte);
   endtask

   task automatic put_random(input int n);
      repeat (n) frame.push_back(8'($urandom));
   endtask

   task automatic put_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) frame.push_back(w[i*8 +: 8]);
   endtask

   task automatic put_record(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] w, input logic [31:0] h,
                             input logic [7:0] flag);
      put_word(x);
      put_word(y);
      put_word(w);
      put_word(h);
      frame.push_back(flag);
   endtask

   task automatic cut_frame(input int keep);
      while (frame.size() > keep) void'(frame.pop_back());
   endtask

   task automatic emit_frame();
      rx_byte_type rb;
      for (int i = 0; i < frame.size(); i++) begin
         rb.value = frame[i];
         rb.is_last = (i == frame.size() - 1);
         rx_bytes_pending.push_back(rb);
      end
      frames_sent++;
   endtask

   task automatic build_push(input int len, input logic [31:0] e, input logic [31:0] t);
      start_frame(8'(sspar_pkg::MSG_PUSH));
      put_random(sspar_pkg::ID_BYTES);
      frame.push_back(8'(len));
      put_random(len);
      put_word(e);
      put_word(t);
   endtask

   task automatic build_valid(input sspar_pkg::msg_type_type t);
      int count;
      int len;
      if (t == sspar_pkg::MSG_PUSH) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, sspar_pkg::NAME_BYTES - 1)
                                             : $urandom_range(0, 12);
         build_push(len, pick_word(), pick_word());
      end else begin
         start_frame(8'(t));
         put_random(sspar_pkg::ID_BYTES);
         if (t == sspar_pkg::MSG_REPLY) begin
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, sspar_pkg::MAX_DISPLAYS)
                                                : $urandom_range(0, 4);
            frame.push_back(8'(count));
            repeat (count) put_record(pick_word(), pick_word(), pick_word(), pick_word(),
                                      pick_flag());
         end
      end
   endtask

   task automatic add_random_datagram();
      int sel;
      int v;
      sel = $urandom_range(0, 99);
      build_valid(sspar_pkg::msg_type_type'($urandom_range(1, 3)));
      if (sel < 72) begin
         if ($urandom_range(0, 4) == 0) put_random($urandom_range(1, 4));
      end else if (sel < 80) begin
         cut_frame($urandom_range(1, frame.size() - 1));
      end else if (sel < 86) begin
         v = $urandom_range(0, 4);
         frame[v] = frame[v] ^ 8'($urandom_range(1, 255));
      end else if (sel < 90) begin
         v = $urandom_range(3, 255);
         frame[5] = (v == 3) ? 8'h00 : 8'(v);
      end else if (sel < 94) begin
         start_frame(8'(sspar_pkg::MSG_REPLY));
         put_random(sspar_pkg::ID_BYTES);
         frame.push_back(8'($urandom_range(sspar_pkg::MAX_DISPLAYS + 1, 255)));
         put_random($urandom_range(0, 20));
      end else if (sel < 97) begin
         start_frame(8'(sspar_pkg::MSG_PUSH));
         put_random(sspar_pkg::ID_BYTES);
         frame.push_back(8'($urandom_range(sspar_pkg::NAME_BYTES, 255)));
         put_random($urandom_range(0, 20));
      end else begin
         frame.delete();
         put_random($urandom_range(1, 12));
      end
      emit_frame();
   endtask

   // ---------------- stimulus and end of run ----------------

   initial begin
      clear_parser_state();

      build_valid(sspar_pkg::MSG_QUERY);
      emit_frame();
      build_valid(sspar_pkg::MSG_QUERY);
      cut_frame(sspar_pkg::ID_END - 1);
      emit_frame();
      build_valid(sspar_pkg::MSG_QUERY);
      put_random(3);
      emit_frame();

      start_frame(8'(sspar_pkg::MSG_REPLY));
      put_random(sspar_pkg::ID_BYTES);
      frame.push_back(8'h00);
      emit_frame();
      start_frame(8'(sspar_pkg::MSG_REPLY));
      put_random(sspar_pkg::ID_BYTES);
      frame.push_back(8'(sspar_pkg::MAX_DISPLAYS));
      for (int i = 0; i < sspar_pkg::MAX_DISPLAYS; i++)
         put_record(extreme_word(i), extreme_word(i + 1), extreme_word(i + 2),
                    extreme_word(i + 3), (i % 3 == 0) ? 8'h00 : ((i % 3 == 1) ? 8'h80 : 8'h01));
      emit_frame();
      start_frame(8'(sspar_pkg::MSG_REPLY));
      put_random(sspar_pkg::ID_BYTES);
      frame.push_back(8'(sspar_pkg::MAX_DISPLAYS + 1));
      put_random(4);
      emit_frame();
      start_frame(8'(sspar_pkg::MSG_REPLY));
      put_random(sspar_pkg::ID_BYTES);
      frame.push_back(8'h02);
      put_record(32'h1234_5678, 32'hFFFF_FC00, 32'd1920, 32'd1080, 8'h01);
      put_random(9);
      emit_frame();

      build_push(0, 32'h8000_0000, 32'h7FFF_FFFF);
      emit_frame();
      build_push(sspar_pkg::NAME_BYTES - 1, 32'hFFFF_FFFF, 32'h0000_0000);
      emit_frame();
      build_push(sspar_pkg::NAME_BYTES, 32'h0, 32'h0);
      cut_frame(sspar_pkg::ID_END + 4);
      emit_frame();
      build_push(5, 32'd2, 32'd1);
      cut_frame(frame.size() - 1);
      emit_frame();

      for (int i = 0; i < 4; i++) begin
         build_valid(sspar_pkg::MSG_QUERY);
         frame[i] = frame[i] ^ 8'h20;
         cut_frame(8);
         emit_frame();
      end
      build_valid(sspar_pkg::MSG_QUERY);
      frame[4] = 8'h00;
      cut_frame(8);
      emit_frame();
      build_valid(sspar_pkg::MSG_QUERY);
      frame[4] = 8'h02;
      cut_frame(8);
      emit_frame();
      build_valid(sspar_pkg::MSG_QUERY);
      frame[5] = 8'h00;
      cut_frame(8);
      emit_frame();
      build_valid(sspar_pkg::MSG_QUERY);
      frame[5] = 8'hFF;
      cut_frame(8);
      emit_frame();
      frame.delete();
      frame.push_back(8'hFF);
      emit_frame();

      while (rx_bytes_pending.size() < TOTAL_BYTES) add_random_datagram();

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      while (rx_bytes_pending.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d datagrams (%0d bytes); checked %0d results: %0d id, %0d name,",
               frames_sent, beats_accepted, results_checked, kind_seen[sspar_pkg::KIND_ID],
               kind_seen[sspar_pkg::KIND_NAME]);
      $display("%0d display records, %0d end markers of which %0d valid.",
               kind_seen[sspar_pkg::KIND_RECORD], kind_seen[sspar_pkg::KIND_END], ends_ok);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("FAIL");
      $finish;
   end

   // ---------------- sender ----------------

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || beat_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (rx_bytes_pending.size() > 0) begin
            next_byte = rx_bytes_pending.pop_front();
            req_tdata <= next_byte.value;
            req_tlast <= next_byte.is_last;
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else if ($urandom_range(0, 7) == 0) begin
               burst_left = $urandom_range(100, 300);
               gap_left = 0;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      beat_taken = 1'b0;
   end

   // ---------------- receiver ----------------

   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && beats_accepted >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_phase++;
            if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= (stall_phase % 3 == 0);
               default: rsp_tready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   // ---------------- monitor ----------------

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         if (mismatches < PRINT_CAP)
            $display("%0t ns: %s mismatch on result %0d, expected %0h, got %0h",
                     $time, label, results_checked, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_beat(req_tdata, req_tlast);
            beats_accepted++;
            beat_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_item.result_kind   = sspar_pkg::kind_type'(rsp_tuser);
            seen_item.text_byte     = rsp_tdata[7:0];
            seen_item.item_index    = rsp_tdata[15:8];
            seen_item.rect_x        = rsp_tdata[47:16];
            seen_item.rect_y        = rsp_tdata[79:48];
            seen_item.rect_width    = rsp_tdata[111:80];
            seen_item.rect_height   = rsp_tdata[143:112];
            seen_item.primary_flag  = rsp_tdata[144];
            seen_item.message_type  = sspar_pkg::msg_type_type'(rsp_tdata[146:145]);
            seen_item.message_ok    = rsp_tdata[147];
            seen_item.edge_code     = rsp_tdata[179:148];
            seen_item.target_screen = rsp_tdata[211:180];
            if (expected_results.size() == 0) begin
               if (mismatches < PRINT_CAP)
                  $display("%0t ns: unexpected result beat, expected none, got kind %0d",
                           $time, rsp_tuser);
               mismatches++;
            end else begin
               want_item = expected_results.pop_front();
               check_field("result_kind", 32'(want_item.result_kind),
                           32'(seen_item.result_kind));
               check_field("text_byte", 32'(want_item.text_byte), 32'(seen_item.text_byte));
               check_field("item_index", 32'(want_item.item_index),
                           32'(seen_item.item_index));
               check_field("rect_x", want_item.rect_x, seen_item.rect_x);
               check_field("rect_y", want_item.rect_y, seen_item.rect_y);
               check_field("rect_width", want_item.rect_width, seen_item.rect_width);
               check_field("rect_height", want_item.rect_height, seen_item.rect_height);
               check_field("primary_flag", 32'(want_item.primary_flag),
                           32'(seen_item.primary_flag));
               check_field("message_type", 32'(want_item.message_type),
                           32'(seen_item.message_type));
               check_field("message_ok", 32'(want_item.message_ok),
                           32'(seen_item.message_ok));
               check_field("edge_code", want_item.edge_code, seen_item.edge_code);
               check_field("target_screen", want_item.target_screen,
                           seen_item.target_screen);
               kind_seen[want_item.result_kind]++;
               if (want_item.result_kind == sspar_pkg::KIND_END && want_item.message_ok)
                  ends_ok++;
            end
            results_checked++;
         end
      end
   end

endmodule

// File: filelist.f
sv/sspar_pkg.sv
sv/sspar_parse_core.sv
sv/sspar_rsp_queue.sv
sv/screen_sync_message_parser.sv
tb/sv/testbench.sv
